// File: rtl/epipolar_inlier_counter_assert.svh
// Assertion macros shared by the epipolar inlier counter RTL.
`ifndef EPIPOLAR_INLIER_COUNTER_ASSERT_SVH
`define EPIPOLAR_INLIER_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// Invariant checked at every clock edge outside reset.
`define EIC_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("eic invariant violated");

// Same-cycle implication.
`define EIC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eic implication violated");

// Next-cycle implication.
`define EIC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eic next-cycle implication violated");

`else

`define EIC_ASSERT(lbl, expr)
`define EIC_ASSERT_IMP(lbl, ante, cons)
`define EIC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/eic_pkg.sv
// Shared constants and types for the epipolar inlier counter.
package eic_pkg;

    localparam int COORD_W    = 16;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = 48;
    localparam int THR_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd3;

    localparam logic [THR_W-1:0] THR_RESET = 40'd419430;

    localparam int MAX_POINTS_DEF = 4096;

    // 1.0 in Q4 is 16: a shift by four
    localparam int ONE_SHIFT = 4;

    // M*x1 fits 34 signed bits, the residual 52
    localparam int V_W = 34;
    localparam int R_W = 52;

    localparam int OUT_CNT_W = 13;
    localparam int PCT_W     = 7;
    localparam int PCT_SCALE = 100;

    // classification queue
    localparam int QD   = 2;
    localparam int QP_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    typedef logic [2:0][ROW_W-1:0] t_matrix;

    typedef struct packed {
        logic inlier;
        logic last;
    } t_cls;

endpackage

// File: rtl/eic_fifo.sv
// Short queue of classified items between the front and back ends.
`include "epipolar_inlier_counter_assert.svh"

module eic_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  eic_pkg::t_cls i_cls,
    output logic          o_full,
    input  logic          i_pop,
    output eic_pkg::t_cls o_cls,
    output logic          o_empty
);
    import eic_pkg::*;

    t_cls            r_mem [QD];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QC_W'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_cls   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QP_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    `EIC_ASSERT(a_q_cnt_range, r_cnt <= QC_W'(QD))
    `EIC_ASSERT_IMP(a_q_no_overflow, i_push, !o_full)
    `EIC_ASSERT_IMP(a_q_no_underflow, i_pop, !o_empty)
    `EIC_ASSERT_NXT(a_q_drain, (r_cnt == QC_W'(1)) && i_pop && !i_push, o_empty)

endmodule

// File: rtl/eic_front.sv
// Front end: accepts a correspondence, forms the residual on one MAC, classifies it.
module eic_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [eic_pkg::IN_DATA_W-1:0] i_data,
    input  logic                          i_last,
    input  eic_pkg::t_matrix              i_matrix,
    input  logic [eic_pkg::THR_W-1:0]     i_thr,
    input  logic                          i_full,
    output logic                          o_push,
    output eic_pkg::t_cls                 o_cls
);
    import eic_pkg::*;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_MAC  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    // steps 0..5 build M*x1 row by row, 6..7 fold in x2
    localparam logic [2:0] STEP_R0   = 3'd6;
    localparam logic [2:0] STEP_LAST = 3'd7;

    localparam int P_W = V_W + COEF_W;

    logic [1:0]                r_state;
    logic [2:0]                r_step;
    logic signed [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic                      r_last;
    logic signed [R_W-1:0]     r_acc;
    logic signed [V_W-1:0]     r_v0, r_v1, r_v2;

    logic [1:0]                row;
    logic signed [COEF_W-1:0]  mul_a;
    logic signed [V_W-1:0]     mul_b;
    logic signed [R_W-1:0]     add_term;
    logic signed [P_W-1:0]     prod;
    logic signed [R_W-1:0]     n_acc;
    logic [R_W-1:0]            mag;
    logic                      inlier;
    logic [COEF_W-1:0]         c_lo, c_mid, c_hi;

    assign o_ready = (r_state == FS_IDLE);

    always_comb begin
        row   = r_step[2:1];
        c_lo  = '0;
        c_mid = '0;
        c_hi  = '0;
        if (r_step < STEP_R0) begin
            c_lo  = i_matrix[row][15:0];
            c_mid = i_matrix[row][31:16];
            c_hi  = i_matrix[row][47:32];
            if (r_step[0]) begin
                mul_a    = $signed(c_mid);
                mul_b    = {{(V_W-COORD_W){r_y1[COORD_W-1]}}, r_y1};
                add_term = r_acc;
            end else begin
                mul_a    = $signed(c_lo);
                mul_b    = {{(V_W-COORD_W){r_x1[COORD_W-1]}}, r_x1};
                add_term = $signed({{(R_W-COEF_W){c_hi[COEF_W-1]}}, c_hi}) <<< ONE_SHIFT;
            end
        end else begin
            if (r_step[0]) begin
                mul_a    = r_y2;
                mul_b    = r_v1;
                add_term = r_acc;
            end else begin
                mul_a    = r_x2;
                mul_b    = r_v0;
                add_term = $signed({{(R_W-V_W){r_v2[V_W-1]}}, r_v2}) <<< ONE_SHIFT;
            end
        end
        prod  = mul_a * mul_b;
        n_acc = $signed({{(R_W-P_W){prod[P_W-1]}}, prod}) + add_term;
    end

    always_comb begin
        mag    = r_acc[R_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        inlier = (mag < {{(R_W-THR_W){1'b0}}, i_thr});
    end

    assign o_push     = (r_state == FS_PUSH) && !i_full;
    assign o_cls.inlier = inlier;
    assign o_cls.last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                FS_IDLE: begin
                    if (i_valid) begin
                        r_step  <= '0;
                        r_state <= FS_MAC;
                    end
                end
                FS_MAC: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == STEP_LAST) begin
                        r_state <= FS_PUSH;
                    end
                end
                FS_PUSH: begin
                    if (!i_full) begin
                        r_state <= FS_IDLE;
                    end
                end
                default: begin
                    r_state <= FS_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_valid) begin
            r_x1   <= i_data[15:0];
            r_y1   <= i_data[31:16];
            r_x2   <= i_data[47:32];
            r_y2   <= i_data[63:48];
            r_last <= i_last;
        end
        if (r_state == FS_MAC) begin
            r_acc <= n_acc;
            if (r_step[0] && r_step < STEP_R0) begin
                case (row)
                    2'd0:    r_v0 <= n_acc[V_W-1:0];
                    2'd1:    r_v1 <= n_acc[V_W-1:0];
                    default: r_v2 <= n_acc[V_W-1:0];
                endcase
            end
        end
    end

endmodule

// File: rtl/eic_back.sv
// Back end: running counts, percent divider and the output register.
`include "epipolar_inlier_counter_assert.svh"

module eic_back #(
    parameter int MAX_POINTS = eic_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  eic_pkg::t_cls                 i_cls,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_inlier,
    output logic [eic_pkg::OUT_CNT_W-1:0] o_inl_cnt,
    output logic [eic_pkg::OUT_CNT_W-1:0] o_pts_cnt,
    output logic [eic_pkg::PCT_W-1:0]     o_pct,
    output logic                          o_last
);
    import eic_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = CNT_W + PCT_W;

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_DIV  = 2'd1;
    localparam logic [1:0] BS_OUT  = 2'd2;

    localparam logic [2:0] QBIT_TOP = 3'(PCT_W - 1);

    logic [1:0]           r_state;
    logic [CNT_W-1:0]     r_inl, r_pts;
    logic [2:0]           r_qbit;
    logic [D_W-1:0]       r_rem;
    logic [PCT_W-1:0]     r_q;
    logic                 r_valid;
    logic                 r_inlier;
    logic [OUT_CNT_W-1:0] r_inl_out, r_pts_out;
    logic [PCT_W-1:0]     r_pct;
    logic                 r_last;

    logic [CNT_W-1:0]     n_inl, n_pts;
    logic                 out_free;
    logic                 out_load;
    logic [D_W-1:0]       shifted;
    logic                 ge;

    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = {{OUT_CNT_W{1'b0}}, c};
        return w[OUT_CNT_W-1:0];
    endfunction

    assign out_free = !r_valid || i_ready;
    assign o_pop    = (r_state == BS_IDLE) && !i_empty && out_free;

    // output register takes a new result: plain item at pop, closing item after the divider
    assign out_load = (o_pop && !i_cls.last) || ((r_state == BS_OUT) && out_free);

    always_comb begin
        n_pts = (r_pts < CNT_W'(MAX_POINTS)) ? r_pts + CNT_W'(1) : r_pts;
        n_inl = (i_cls.inlier && r_inl < CNT_W'(MAX_POINTS)) ? r_inl + CNT_W'(1) : r_inl;
    end

    // restoring division, one quotient bit per cycle; quotient never exceeds 100
    assign shifted = {{PCT_W{1'b0}}, r_pts} << r_qbit;
    assign ge      = (r_rem >= shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_valid <= 1'b0;
            r_inl   <= '0;
            r_pts   <= '0;
            r_qbit  <= '0;
        end else begin
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        if (i_cls.last) begin
                            r_inl    <= n_inl;
                            r_pts    <= n_pts;
                            r_inlier <= i_cls.inlier;
                            r_rem    <= D_W'(n_inl) * D_W'(PCT_SCALE);
                            r_q      <= '0;
                            r_qbit   <= QBIT_TOP;
                            r_state  <= BS_DIV;
                        end else begin
                            r_inl     <= n_inl;
                            r_pts     <= n_pts;
                            r_inlier  <= i_cls.inlier;
                            r_inl_out <= to_out(n_inl);
                            r_pts_out <= to_out(n_pts);
                            r_pct     <= '0;
                            r_last    <= 1'b0;
                        end
                    end
                end
                BS_DIV: begin
                    if (ge) begin
                        r_rem       <= r_rem - shifted;
                        r_q[r_qbit] <= 1'b1;
                    end
                    if (r_qbit == 3'd0) begin
                        r_state <= BS_OUT;
                    end else begin
                        r_qbit <= r_qbit - 3'd1;
                    end
                end
                BS_OUT: begin
                    if (out_free) begin
                        r_inl_out <= to_out(r_inl);
                        r_pts_out <= to_out(r_pts);
                        r_pct     <= r_q;
                        r_last    <= 1'b1;
                        r_inl     <= '0;
                        r_pts     <= '0;
                        r_state   <= BS_IDLE;
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_valid;
    assign o_inlier  = r_inlier;
    assign o_inl_cnt = r_inl_out;
    assign o_pts_cnt = r_pts_out;
    assign o_pct     = r_pct;
    assign o_last    = r_last;

    `EIC_ASSERT(a_cnt_order, r_inl <= r_pts)
    `EIC_ASSERT_IMP(a_pct_range, r_valid && r_last, r_pct <= PCT_W'(PCT_SCALE))
    `EIC_ASSERT_IMP(a_pct_zero, r_valid && !r_last, r_pct == '0)
    `EIC_ASSERT_IMP(a_no_pop_busy, r_state != BS_IDLE, !o_pop)

endmodule

// File: rtl/epipolar_inlier_counter.sv
// Top level of the epipolar inlier counter: registers, front end, queue, back end.
//
// Usage:
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0..2 matrix rows, 3 inlier threshold) at the clock edge; write only
//   while no item is in flight.
//   Input stream s_axis: one correspondence per transfer, tdata packs
//   first_x, first_y, second_x, second_y; tlast marks the last of a set.
//   Output stream m_axis: one result per input transfer, in order;
//   tlast is set_done.
//   One item at a time: the single shared multiply-accumulate in the
//   front end runs 8 MAC steps between accept and push. Each result
//   passes through the queue to the output register; the last item of
//   a set also runs the bit-serial percent divider.
//   The two-entry queue and the output register let the front keep scoring
//   while a result waits; when the receiver stalls, tvalid and tdata hold
//   and the queue fills until s_axis_tready drops.
//   Reset (synchronous, active low) clears the counts and sets the matrix
//   to zero and the threshold to 0.1 in Q22.
module epipolar_inlier_counter #(
    parameter int MAX_POINTS = eic_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_x [15:0], first_y [31:16], second_x [47:32], second_y [63:48]
    input  logic [eic_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // is_inlier [0], inlier_count [13:1], point_count [26:14],
    // inlier_percent [33:27], zero [39:34]
    output logic [eic_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [eic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eic_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import eic_pkg::*;

    t_matrix              r_matrix;
    logic [THR_W-1:0]     r_thr;

    logic                 f_push;
    t_cls                 f_cls;
    logic                 q_full;
    logic                 q_empty;
    t_cls                 q_cls;
    logic                 b_pop;
    logic                 b_inlier;
    logic [OUT_CNT_W-1:0] b_inl_cnt;
    logic [OUT_CNT_W-1:0] b_pts_cnt;
    logic [PCT_W-1:0]     b_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= '0;
            r_thr    <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW0: r_matrix[0] <= i_cfg_data[ROW_W-1:0];
                REG_ROW1: r_matrix[1] <= i_cfg_data[ROW_W-1:0];
                REG_ROW2: r_matrix[2] <= i_cfg_data[ROW_W-1:0];
                REG_THR:  r_thr       <= i_cfg_data[THR_W-1:0];
            endcase
        end
    end

    eic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_matrix (r_matrix),
        .i_thr    (r_thr),
        .i_full   (q_full),
        .o_push   (f_push),
        .o_cls    (f_cls)
    );

    eic_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cls   (f_cls),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_cls   (q_cls),
        .o_empty (q_empty)
    );

    eic_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_cls     (q_cls),
        .o_pop     (b_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_inlier  (b_inlier),
        .o_inl_cnt (b_inl_cnt),
        .o_pts_cnt (b_pts_cnt),
        .o_pct     (b_pct),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {
        {(OUT_DATA_W - 1 - 2*OUT_CNT_W - PCT_W){1'b0}},
        b_pct,
        b_pts_cnt,
        b_inl_cnt,
        b_inlier
    };

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the epipolar inlier counter stream block.
module tb;
    import eic_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_SHOWN     = 40;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 90;

    typedef struct packed {
        logic                 inlier;
        logic [OUT_CNT_W-1:0] inliers;
        logic [OUT_CNT_W-1:0] points;
        logic [PCT_W-1:0]     percent;
        logic                 done;
    } t_score;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // first_x [15:0], first_y [31:16], second_x [47:32], second_y [63:48]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // is_inlier [0], inlier_count [13:1], point_count [26:14],
    // inlier_percent [33:27], zero [39:34]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // shadow copy of the matrix, threshold and running counts
    logic [ROW_W-1:0] mat_row [3] = '{default: '0};
    logic [THR_W-1:0] thr_q22     = THR_RESET;
    int               inl_seen    = 0;
    int               pts_seen    = 0;

    t_score pending_scores[$];
    int     err_count  = 0;
    int     result_idx = 0;
    bit     tx_idle    = 1'b0;
    bit     rx_idle    = 1'b0;
    int     hold_req   = 0;
    int     hold_seen  = 0;
    int     rx_stall   = 0;

    always #5 i_clk = ~i_clk;

    epipolar_inlier_counter u_top (.*);

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(4) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(logic [15:0] c0, c1, c2);
        return {c2, c1, c0};
    endfunction

    function automatic longint coef(int row, int col);
        logic signed [COEF_W-1:0] c;
        c = mat_row[row][col*COEF_W +: COEF_W];
        return c;
    endfunction

    // x2^T * M * x1 in Q22, homogeneous 1.0 is 16 (Q4)
    function automatic longint residual(input logic signed [COORD_W-1:0] fx, fy, sx, sy);
        longint v [3];
        for (int i = 0; i < 3; i++)
            v[i] = coef(i, 0) * fx + coef(i, 1) * fy + (coef(i, 2) <<< ONE_SHIFT);
        return sx * v[0] + sy * v[1] + (v[2] <<< ONE_SHIFT);
    endfunction

    function automatic t_score score_match(input logic signed [COORD_W-1:0] fx, fy, sx, sy,
                                           input logic last);
        t_score s;
        longint mag;
        mag = residual(fx, fy, sx, sy);
        if (mag < 0)
            mag = -mag;
        s.inlier = mag < longint'({24'd0, thr_q22});
        if (pts_seen < MAX_POINTS_DEF)
            pts_seen++;
        if (s.inlier && inl_seen < MAX_POINTS_DEF)
            inl_seen++;
        s.inliers = OUT_CNT_W'(inl_seen);
        s.points  = OUT_CNT_W'(pts_seen);
        s.percent = last ? PCT_W'((inl_seen * PCT_SCALE) / pts_seen) : '0;
        s.done    = last;
        if (last) begin
            inl_seen = 0;
            pts_seen = 0;
        end
        return s;
    endfunction

    function automatic logic [15:0] pick_coord(int cls);
        case (cls)
            0: return 16'($urandom_range(128) - 64);
            1: return 16'($urandom);
            default: begin
                case ($urandom_range(2))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row(int cls);
        logic [ROW_W-1:0] row;
        for (int c = 0; c < 3; c++) begin
            case (cls)
                0: row[c*COEF_W +: COEF_W] = COEF_W'($urandom);
                1: row[c*COEF_W +: COEF_W] = COEF_W'($urandom_range(32) - 16);
                default: row[c*COEF_W +: COEF_W] =
                    ($urandom_range(1) == 0) ? '0 : COEF_W'($urandom);
            endcase
        end
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("result %0d: %s got %0d want %0d", result_idx, what, got, want);
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2: mat_row[idx] = data[ROW_W-1:0];
            REG_THR:                      thr_q22 = data[THR_W-1:0];
            default: ;
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_matrix(input logic [ROW_W-1:0] r0, r1, r2);
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
    endtask

    // returns at the edge where the transfer happens
    task automatic send_match(input logic [15:0] fx, fy, sx, sy, input logic last);
        int gap;
        gap = (tx_idle && $urandom_range(2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_scores.insert(pending_scores.size(), score_match(fx, fy, sx, sy, last));
        s_axis_tdata  <= {sy, sx, fy, fx};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bit k of inl_mask set: item k lands well inside the threshold
    task automatic send_pattern(input int n, input logic [15:0] inl_mask);
        logic [15:0] fx;
        for (int k = 0; k < n; k++) begin
            fx = inl_mask[k] ? 16'($urandom_range(400)) : ((k % 2) ? 16'h7FFF : 16'h8000);
            send_match(fx, 16'($urandom), 16'($urandom), 16'($urandom), k == n - 1);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        // zero matrix after reset: every residual is zero
        send_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_match(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_match(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_match(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        drain_results();
    endtask

    task automatic test_coord_extremes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // bits above the 40-bit threshold must be dropped
        write_reg(REG_THR, 48'hFFFF_FFFF_FFFF);
        write_matrix(pack_row(16'h8000, 16'h8000, 16'h8000),
                     pack_row(16'h8000, 16'h8000, 16'h8000),
                     pack_row(16'h8000, 16'h8000, 16'h8000));
        send_match(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_match(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        drain_results();
        write_matrix(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     pack_row(16'h8000, 16'h0000, 16'h7FFF),
                     pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_match(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_match(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_match(16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
        drain_results();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
    endtask

    task automatic test_threshold_boundary();
        longint mag;
        write_reg(REG_THR, CFG_DATA_W'(THR_RESET));
        write_matrix(pack_row(16'd3, -16'sd5, 16'd7),
                     pack_row(-16'sd2, 16'd11, 16'd1),
                     pack_row(16'd4, 16'd6, -16'sd9));
        mag = residual(16'sd100, -16'sd37, 16'sd250, -16'sd81);
        if (mag < 0)
            mag = -mag;
        // |r| equal to the bound is not an inlier, one above it is
        write_reg(REG_THR, CFG_DATA_W'(mag));
        send_match(16'd100, -16'sd37, 16'd250, -16'sd81, 1'b1);
        drain_results();
        write_reg(REG_THR, CFG_DATA_W'(mag + 1));
        send_match(16'd100, -16'sd37, 16'd250, -16'sd81, 1'b1);
        drain_results();
        // zero threshold: even a zero residual fails
        write_reg(REG_THR, '0);
        write_matrix('0, '0, '0);
        send_match(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        drain_results();
    endtask

    task automatic test_inlier_percent();
        // residual = 16 * first_x, so first_x alone decides
        write_reg(REG_THR, CFG_DATA_W'(THR_RESET));
        write_matrix('0, '0, pack_row(16'd1, 16'd0, 16'd0));
        send_pattern(1, 16'b1);
        send_pattern(1, 16'b0);
        send_pattern(3, 16'b010);
        send_pattern(3, 16'b101);
        send_pattern(5, 16'b10000);
        drain_results();
    endtask

    task automatic test_output_stall();
        // receiver holds off while the sender keeps offering transfers
        hold_req <= hold_req + 1;
        for (int k = 0; k < 16; k++)
            send_match(16'($urandom_range(600)), 16'($urandom), 16'($urandom),
                       16'($urandom), k % 5 == 4);
        drain_results();
    endtask

    task automatic test_random_sets();
        int mcls;
        int set_len;
        int sent;
        int ccls;
        logic [THR_W-1:0] bound;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mcls = $urandom_range(2);
            write_matrix(rand_row(mcls), rand_row(mcls), rand_row(mcls));
            if (ph == 0)
                bound = '0;
            else if (ph == 1)
                bound = '1;
            else begin
                bound = THR_W'({$urandom, $urandom});
                bound = bound >> $urandom_range(THR_W - 8);
            end
            write_reg(REG_THR, {8'($urandom), bound});
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                set_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
                tx_idle = $urandom_range(2) != 0;
                rx_idle = $urandom_range(2) != 0;
                for (int k = 0; k < set_len; k++) begin
                    ccls = ($urandom_range(9) == 0) ? 2 : $urandom_range(1);
                    send_match(pick_coord(ccls), pick_coord(ccls), pick_coord(ccls),
                               pick_coord(ccls), k == set_len - 1);
                end
                sent += set_len;
            end
            drain_results();
        end
        tx_idle = 1'b0;
        rx_idle = 1'b0;
    endtask

    // ------------------------------------------------------------- processes

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            rx_stall      <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(3) == 0) begin
            rx_stall      <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : score_check
        t_score want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_scores.size() == 0) begin
                flag_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_scores.pop_front();
                check_field("is_inlier", longint'(m_axis_tdata[0]), longint'(want.inlier));
                check_field("inlier_count", longint'(m_axis_tdata[13:1]),
                            longint'(want.inliers));
                check_field("point_count", longint'(m_axis_tdata[26:14]),
                            longint'(want.points));
                check_field("inlier_percent", longint'(m_axis_tdata[33:27]),
                            longint'(want.percent));
                check_field("pad bits", longint'(m_axis_tdata[39:34]), 0);
                check_field("set_done", longint'(m_axis_tlast), longint'(want.done));
            end
            result_idx++;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_coord_extremes();
        test_threshold_boundary();
        test_inlier_percent();
        test_output_stall();
        test_random_sets();
        while (pending_scores.size() != 0) begin
            void'(pending_scores.pop_front());
            flag_mismatch("missing result", 0, 1);
        end
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
